/* rtl/core/pvm_pkg.sv */
// ----------------------------------------------------------------------------
// pvm_pkg
// Shared types and constants for the PCM voice mixer.
// ----------------------------------------------------------------------------
package pvm_pkg;

    // Operation codes carried in the low bits of s_tdata
    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_WRITE = 3'd1,
        OP_SET   = 3'd2,
        OP_PLAY  = 3'd3,
        OP_STOP  = 3'd4
    } op_t;

    localparam int unsigned OP_W     = 3;
    localparam int unsigned CLIP_W   = 5;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned END_W    = 17;
    localparam logic [7:0]  SILENCE  = 8'h80;

endpackage

/* rtl/core/pcm_voice_mixer.sv */
// ----------------------------------------------------------------------------
// pcm_voice_mixer
// Mixes up to VOICE_SLOTS-1 unsigned 8-bit PCM voices from a sample memory.
// ----------------------------------------------------------------------------
// Timing: with A active voices, a tick transfer walks each voice through ST_READ and
// ST_ADD, then ST_END and ST_OUT; when the sample ends a chunk, a removal scan (one
// slot per cycle) comes before ST_OUT. Throughput: one item at a time, as s_tready is
// high only in ST_IDLE. One sample read per voice from the single-port memory sets the
// tick time; A is at most VOICE_SLOTS-1 (7 by default).
// Reset: asynchronous, active low; clears clip valid marks, active count, chunk
// count and control. The sample memory has no reset.
module pcm_voice_mixer
    import pvm_pkg::*;
#(
    parameter int unsigned SAMPLE_DEPTH = 65536,
    parameter int unsigned CLIP_COUNT   = 26,
    parameter int unsigned VOICE_SLOTS  = 8,
    parameter int unsigned CHUNK_LENGTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[2:0], mem_address[18:3], sample_byte[26:19], clip_id[31:27],
    // clip_first[47:32], clip_limit[64:48], clip_usable[65], zero fill
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // mixed_sample[7:0]
    output logic [7:0]  m_tdata,
    // chunk_last
    output logic        m_tlast
);

    localparam int unsigned AW  = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
    localparam int unsigned CIW = (CLIP_COUNT > 1) ? $clog2(CLIP_COUNT) : 1;
    localparam int unsigned VW  = $clog2(VOICE_SLOTS);
    localparam int unsigned NW  = $clog2(VOICE_SLOTS + 1);
    localparam int unsigned KW  = $clog2(CHUNK_LENGTH + 1);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_READ  = 7'b0000010,  // issue sample read for voice
        ST_ADD   = 7'b0000100,  // accumulate returned sample
        ST_END   = 7'b0001000,  // chunk decision
        ST_SCAN  = 7'b0010000,  // removal scan, highest slot down
        ST_ACT   = 7'b0100000,  // play / set action after scan
        ST_OUT   = 7'b1000000
    } state_t;

    typedef enum logic [1:0] {
        SC_FIN  = 2'd0,
        SC_CLIP = 2'd1
    } scan_t;

    // Input fields
    op_t                op_in;
    logic [15:0]        addr_in;
    logic [7:0]         byte_in;
    logic [CLIP_W-1:0]  clip_in;
    logic [15:0]        first_in;
    logic [END_W-1:0]   limit_in;
    logic               usable_in;
    assign op_in     = op_t'(s_tdata[2:0]);
    assign addr_in   = s_tdata[18:3];
    assign byte_in   = s_tdata[26:19];
    assign clip_in   = s_tdata[31:27];
    assign first_in  = s_tdata[47:32];
    assign limit_in  = s_tdata[64:48];
    assign usable_in = s_tdata[65];

    // Storage
    logic [7:0]        smem [SAMPLE_DEPTH];
    logic [7:0]        smem_q;
    logic [15:0]       cstart [CLIP_COUNT];
    logic [END_W-1:0]  cend   [CLIP_COUNT];
    logic [CLIP_COUNT-1:0] cvalid_reg;
    logic [CIW-1:0]    vclip [VOICE_SLOTS];
    logic [END_W-1:0]  vpos  [VOICE_SLOTS];
    logic [END_W-1:0]  vend  [VOICE_SLOTS];

    state_t            state_reg;
    scan_t             scan_mode_reg;
    logic [NW-1:0]     active_reg;
    logic [KW-1:0]     chunk_reg;
    logic [VW-1:0]     idx_reg;
    logic [NW-1:0]     scan_reg;
    logic [8:0]        mix_reg;
    logic              any_reg, left_reg, last_reg;
    op_t               op_reg;
    logic [CIW-1:0]    clip_reg;
    logic [15:0]       first_reg;
    logic [END_W-1:0]  limit_reg;
    logic              usable_reg;
    logic              has_reg;  // current voice has data

    logic              acc_in;
    logic              clip_ok;
    logic [VW-1:0]     sidx, last_idx;
    logic              drop_hit;
    logic [9:0]        sum;
    logic [8:0]        sat;

    assign s_tready = (state_reg == ST_IDLE);
    assign acc_in   = s_tvalid && s_tready;
    assign clip_ok  = ({1'b0, clip_in} < (CLIP_W+1)'(CLIP_COUNT));
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = mix_reg[7:0];
    assign m_tlast  = last_reg;

    assign sidx     = VW'(scan_reg - NW'(1));
    assign last_idx = VW'(active_reg - NW'(1));
    assign drop_hit = (scan_mode_reg == SC_FIN) ? (vpos[sidx] >= vend[sidx])
                                                : (vclip[sidx] == clip_reg);

    // Saturating add of sample minus silence
    assign sum = {1'b0, mix_reg} + {2'b00, smem_q} - 10'(SILENCE);
    assign sat = sum[9] ? 9'd0 : ((sum > 10'd255) ? 9'd255 : sum[8:0]);

    // Sample memory: one port, read in ST_READ, write on accept
    always_ff @(posedge clk)
    begin
        if (acc_in && op_in == OP_WRITE)
        begin
            smem[AW'(addr_in)] <= byte_in;
        end
        smem_q <= smem[AW'(vpos[idx_reg])];
    end

    // Clip table and voice slots (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ACT && op_reg == OP_SET)
        begin
            cstart[clip_reg] <= usable_reg ? first_reg : 16'd0;
            cend[clip_reg]   <= usable_reg ? limit_reg : '0;
        end
        if (state_reg == ST_ACT && op_reg == OP_PLAY && cvalid_reg[clip_reg]
            && (active_reg + NW'(1) < NW'(VOICE_SLOTS)))
        begin
            vclip[VW'(active_reg)] <= clip_reg;
            vpos[VW'(active_reg)]  <= END_W'(cstart[clip_reg]);
            vend[VW'(active_reg)]  <= cend[clip_reg];
        end
        if (state_reg == ST_READ && has_reg)
        begin
            vpos[idx_reg] <= vpos[idx_reg] + END_W'(1);
        end
        if (state_reg == ST_SCAN && scan_reg != '0 && drop_hit)
        begin
            vclip[sidx] <= vclip[last_idx];
            vpos[sidx]  <= vpos[last_idx];
            vend[sidx]  <= vend[last_idx];
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_mode_reg <= SC_FIN;
            active_reg    <= '0;
            chunk_reg     <= '0;
            cvalid_reg    <= '0;
            idx_reg       <= '0;
            scan_reg      <= '0;
            mix_reg       <= 9'(SILENCE);
            any_reg       <= 1'b0;
            left_reg      <= 1'b0;
            last_reg      <= 1'b0;
            has_reg       <= 1'b0;
            op_reg        <= OP_TICK;
            clip_reg      <= '0;
            first_reg     <= '0;
            limit_reg     <= '0;
            usable_reg    <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (acc_in)
                    begin
                        op_reg     <= op_in;
                        clip_reg   <= CIW'(clip_in);
                        first_reg  <= first_in;
                        limit_reg  <= limit_in;
                        usable_reg <= usable_in;
                        scan_reg   <= active_reg;
                        idx_reg    <= '0;
                        mix_reg    <= 9'(SILENCE);
                        any_reg    <= 1'b0;
                        left_reg   <= 1'b0;
                        if (op_in == OP_TICK)
                        begin
                            has_reg   <= (active_reg != '0) && (vpos[0] < vend[0]);
                            state_reg <= (active_reg != '0) ? ST_READ : ST_IDLE;
                        end
                        else if (clip_ok && op_in == OP_SET)
                        begin
                            scan_mode_reg <= SC_CLIP;
                            state_reg     <= ST_SCAN;
                        end
                        else if (clip_ok && (op_in == OP_PLAY || op_in == OP_STOP))
                        begin
                            scan_mode_reg <= SC_FIN;
                            state_reg     <= (chunk_reg != '0) ? ST_SCAN : ST_ACT;
                            chunk_reg     <= '0;
                        end
                    end
                end
                ST_READ:
                begin
                    if (has_reg)
                    begin
                        any_reg <= 1'b1;
                        if (vpos[idx_reg] + END_W'(1) < vend[idx_reg])
                        begin
                            left_reg <= 1'b1;
                        end
                    end
                    state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    if (has_reg)
                    begin
                        mix_reg <= sat;
                    end
                    if (NW'(idx_reg) + NW'(1) < active_reg)
                    begin
                        idx_reg   <= idx_reg + VW'(1);
                        has_reg   <= vpos[idx_reg + VW'(1)] < vend[idx_reg + VW'(1)];
                        state_reg <= ST_READ;
                    end
                    else
                    begin
                        state_reg <= ST_END;
                    end
                end
                ST_END:
                begin
                    if (!any_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if ((chunk_reg + KW'(1) >= KW'(CHUNK_LENGTH)) || !left_reg)
                    begin
                        last_reg      <= 1'b1;
                        chunk_reg     <= '0;
                        scan_mode_reg <= SC_FIN;
                        scan_reg      <= active_reg;
                        state_reg     <= ST_SCAN;
                    end
                    else
                    begin
                        last_reg  <= 1'b0;
                        chunk_reg <= chunk_reg + KW'(1);
                        state_reg <= ST_OUT;
                    end
                end
                ST_SCAN:
                begin
                    if (scan_reg == '0)
                    begin
                        if (op_reg == OP_TICK)
                        begin
                            state_reg <= ST_OUT;
                        end
                        else if (scan_mode_reg == SC_FIN && op_reg == OP_STOP)
                        begin
                            scan_mode_reg <= SC_CLIP;
                            scan_reg      <= active_reg;
                        end
                        else
                        begin
                            state_reg <= ST_ACT;
                        end
                    end
                    else
                    begin
                        if (drop_hit)
                        begin
                            active_reg <= active_reg - NW'(1);
                        end
                        scan_reg <= scan_reg - NW'(1);
                    end
                end
                ST_ACT:
                begin
                    if (op_reg == OP_STOP && scan_mode_reg == SC_FIN)
                    begin
                        scan_mode_reg <= SC_CLIP;
                        scan_reg      <= active_reg;
                        state_reg     <= ST_SCAN;
                    end
                    else
                    begin
                        if (op_reg == OP_SET)
                        begin
                            cvalid_reg[clip_reg] <= usable_reg;
                        end
                        if (op_reg == OP_PLAY && cvalid_reg[clip_reg]
                            && (active_reg + NW'(1) < NW'(VOICE_SLOTS)))
                        begin
                            active_reg <= active_reg + NW'(1);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                ST_OUT:
                begin
                    if (m_tready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    // Active count never reaches the slot count
    a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg < NW'(VOICE_SLOTS))
        else $error("active voice count overflow");

    // Chunk count stays below the chunk length
    a_chunk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        chunk_reg < KW'(CHUNK_LENGTH))
        else $error("chunk count overflow");

    // A result holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("result changed while stalled");

    // Removal never raises the active count
    a_scan_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |=> (active_reg <= $past(active_reg)))
        else $error("active count rose during removal");
`endif

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for pcm_voice_mixer: clip, play, stop and tick traffic
// is predicted by a local mixer model and each output transfer is compared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import pvm_pkg::*;

    localparam int CLIPS      = 26;
    localparam int SLOTS      = 8;
    localparam int CHUNK      = 1024;
    localparam int STALL_LIM  = 20000;

    // Unassigned operation codes, expected to be ignored
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    pcm_voice_mixer uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Mixer state mirror
    logic [7:0]  mem_img [0:65535];
    logic [15:0] clip_start [0:CLIPS-1];
    logic [16:0] clip_end [0:CLIPS-1];
    logic        clip_ok [0:CLIPS-1];
    logic [4:0]  v_clip [0:SLOTS-1];
    logic [16:0] v_pos [0:SLOTS-1];
    logic [16:0] v_end [0:SLOTS-1];
    int          n_active;
    int          chunk_cnt;

    logic [8:0]  mix_queue [$];   // {chunk_last, sample}
    int          err_cnt;
    int          mix_cnt;
    int          last_cnt;
    int          idle_cycles;
    bit          allow_idle;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_err(input string msg);
        $display("tb: mismatch: %s", msg);
        err_cnt++;
    endtask

    function automatic void drop_slot(input int s);
        n_active--;
        v_clip[s] = v_clip[n_active];
        v_pos[s]  = v_pos[n_active];
        v_end[s]  = v_end[n_active];
    endfunction

    function automatic void drop_finished();
        for (int i = n_active - 1; i >= 0; i--)
            if (v_pos[i] >= v_end[i])
                drop_slot(i);
    endfunction

    function automatic void drop_clip(input logic [4:0] c);
        for (int i = n_active - 1; i >= 0; i--)
            if (v_clip[i] == c)
                drop_slot(i);
    endfunction

    function automatic void cut_chunk();
        if (chunk_cnt != 0)
        begin
            drop_finished();
            chunk_cnt = 0;
        end
    endfunction

    // Advance the mirror by one item and queue the mixed sample, if any
    function automatic void predict_mix(input logic [71:0] d);
        logic [2:0]  op;
        logic [4:0]  c;
        int          mix;
        bit          any;
        bit          left;
        bit          last;
        op = d[2:0];
        c  = d[31:27];
        mix = 8'h80;
        any = 0;
        left = 0;
        if (op == OP_TICK)
        begin
            for (int i = 0; i < n_active; i++)
                if (v_pos[i] < v_end[i])
                begin
                    any = 1;
                    mix = mix + int'(mem_img[v_pos[i][15:0]]) - 128;
                    if (mix < 0) mix = 0;
                    if (mix > 255) mix = 255;
                    v_pos[i]++;
                    if (v_pos[i] < v_end[i]) left = 1;
                end
            if (any)
            begin
                chunk_cnt++;
                last = (chunk_cnt >= CHUNK) || !left;
                if (last)
                begin
                    drop_finished();
                    chunk_cnt = 0;
                end
                mix_queue.push_back({last, mix[7:0]});
            end
        end
        else if (op == OP_WRITE)
        begin
            mem_img[d[18:3]] = d[26:19];
        end
        else if (c < CLIPS)
        begin
            if (op == OP_SET)
            begin
                drop_clip(c);
                clip_ok[c]    = d[65];
                clip_start[c] = d[65] ? d[47:32] : 16'd0;
                clip_end[c]   = d[65] ? d[64:48] : 17'd0;
            end
            else if (op == OP_PLAY)
            begin
                cut_chunk();
                if (clip_ok[c] && n_active + 1 < SLOTS)
                begin
                    v_clip[n_active] = c;
                    v_pos[n_active]  = 17'(clip_start[c]);
                    v_end[n_active]  = clip_end[c];
                    n_active++;
                end
            end
            else if (op == OP_STOP)
            begin
                cut_chunk();
                drop_clip(c);
            end
        end
    endfunction

    function automatic logic [71:0] pack(input logic [2:0] op, input logic [15:0] a,
                                         input logic [7:0] b, input logic [4:0] c,
                                         input logic [15:0] f, input logic [16:0] l,
                                         input logic u);
        return {6'd0, u, l, f, c, b, a, op};
    endfunction

    // Send one item, with optional random gap before it
    task automatic send_item(input logic [71:0] d);
        int gap;
        if (allow_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 17);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_mix(d);
    endtask

    task automatic write_sample(input logic [15:0] a, input logic [7:0] b);
        send_item(pack(OP_WRITE, a, b, '0, '0, '0, '0));
    endtask

    task automatic set_clip(input logic [4:0] c, input logic [15:0] f,
                            input logic [16:0] l, input logic u);
        send_item(pack(OP_SET, 16'($urandom), 8'($urandom), c, f, l, u));
    endtask

    task automatic play_clip(input logic [4:0] c);
        send_item(pack(OP_PLAY, 16'($urandom), 8'($urandom), c, 16'($urandom),
                       17'($urandom), 1'($urandom)));
    endtask

    task automatic stop_clip(input logic [4:0] c);
        send_item(pack(OP_STOP, 16'($urandom), 8'($urandom), c, 16'($urandom),
                       17'($urandom), 1'($urandom)));
    endtask

    task automatic tick();
        send_item(pack(OP_TICK, 16'($urandom), 8'($urandom), 5'($urandom),
                       16'($urandom), 17'($urandom), 1'($urandom)));
    endtask

    // Directed: extremes, saturation, every operation and odd cases
    task automatic test_directed();
        write_sample(16'h0000, 8'hFF);
        write_sample(16'h0001, 8'h00);
        write_sample(16'hFFFF, 8'hFF);
        write_sample(16'hFFFE, 8'h80);
        set_clip(5'd0, 16'h0000, 17'd2, 1'b1);
        set_clip(5'd25, 16'hFFFE, 17'h10000, 1'b1);
        set_clip(5'd3, 16'h0001, 17'd1, 1'b1);          // empty clip
        set_clip(5'd4, 16'hFFFF, 17'h1FFFF, 1'b0);       // invalidated
        set_clip(5'd31, 16'h0000, 17'd2, 1'b1);          // out of range id
        play_clip(5'd0);
        play_clip(5'd0);
        play_clip(5'd25);
        play_clip(5'd3);
        play_clip(5'd4);
        play_clip(5'd31);
        tick();
        tick();
        send_item(pack(OP_UNUSED_LO, 16'hFFFF, 8'hFF, 5'd31, 16'hFFFF, 17'h1FFFF, 1'b1));
        send_item(pack(OP_UNUSED_HI, '0, '0, '0, '0, '0, '0));
        tick();
        stop_clip(5'd31);
        play_clip(5'd0);
        tick();
        stop_clip(5'd0);
        tick();
        tick();
    endtask

    // Random: mostly well-formed clip traffic over a small memory window
    task automatic test_random(input int count);
        int r;
        logic [15:0] f;
        logic [16:0] l;
        for (int a = 0; a < 64; a++)
            write_sample(a[15:0], 8'($urandom));
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                tick();
            else if (r < 63)
                write_sample(16'($urandom_range(0, 63)), 8'($urandom));
            else if (r < 71)
            begin
                f = 16'($urandom_range(0, 63));
                l = 17'($urandom_range(0, 64));
                if ($urandom_range(0, 15) == 0)
                    send_item(pack(OP_SET, 16'($urandom), 8'($urandom),
                                   5'($urandom_range(26, 31)), 16'($urandom),
                                   17'($urandom), 1'($urandom)));
                else
                    set_clip(5'($urandom_range(0, 25)), f, l, $urandom_range(0, 7) != 0);
            end
            else if (r < 90)
                play_clip(5'($urandom_range(0, 27)));
            else if (r < 96)
                stop_clip(5'($urandom_range(0, 27)));
            else
                send_item(pack(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)),
                               16'($urandom), 8'($urandom), 5'($urandom),
                               16'($urandom), 17'($urandom), 1'($urandom)));
        end
    endtask

    // Long clip played out to its natural end
    task automatic test_long_clip();
        for (int a = 0; a < 200; a++)
            write_sample(16'h1000 + a[15:0], 8'($urandom));
        set_clip(5'd10, 16'h1000, 17'h1000 + 17'd200, 1'b1);
        play_clip(5'd10);
        for (int n = 0; n < 210; n++)
            tick();
    endtask

    // Output side: random stalls, checks every transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (mix_queue.size() == 0)
                    report_err($sformatf("unexpected sample %02h", m_tdata));
                else
                begin
                    logic [8:0] exp_mix;
                    exp_mix = mix_queue.pop_front();
                    mix_cnt++;
                    if (m_tlast) last_cnt++;
                    if (m_tdata !== exp_mix[7:0])
                        report_err($sformatf("sample %02h, want %02h", m_tdata, exp_mix[7:0]));
                    if (m_tlast !== exp_mix[8])
                        report_err($sformatf("chunk_last %b, want %b", m_tlast, exp_mix[8]));
                end
            end
            if (allow_idle && $urandom_range(0, 7) == 0)
                m_tready <= 1'b0;
            else if (!m_tready && allow_idle && $urandom_range(0, 17) != 0)
                m_tready <= 1'b0;
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIM)
        begin
            $display("tb: timeout");
            $display("tb: errors");
            $finish;
        end
    end

    initial
    begin
        int wait_cnt;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        err_cnt = 0;
        mix_cnt = 0;
        last_cnt = 0;
        idle_cycles = 0;
        allow_idle = 1;
        n_active = 0;
        chunk_cnt = 0;
        for (int i = 0; i < 65536; i++)
            mem_img[i] = 8'h00;
        for (int i = 0; i < CLIPS; i++)
        begin
            clip_start[i] = '0;
            clip_end[i] = '0;
            clip_ok[i] = 0;
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            v_clip[i] = '0;
            v_pos[i] = '0;
            v_end[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(700);
        test_long_clip();
        allow_idle = 0;
        test_random(200);
        s_tvalid <= 1'b0;
        wait_cnt = 0;
        while (mix_queue.size() != 0 && wait_cnt < 100000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (40) @(posedge clk);
        $display("tb: %0d samples checked, %0d chunk ends; writes, clip set, play, stop,",
                 mix_cnt, last_cnt);
        $display("tb: silent ticks, unknown codes and a long clip run to its end");
        if (err_cnt == 0 && mix_queue.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
